>>> rtl/core/pic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg
// shared types, codes and constants of the priority interrupt controller
// ----------------------------------------------------------------------------
package pic_pkg;

   localparam int NUM_SOURCES = 24;
   localparam int SRC_W       = 5;
   localparam int NUM_GROUPS  = 4;
   localparam int GROUP_SIZE  = NUM_SOURCES / NUM_GROUPS;

   // source numbers
   localparam int SRC_NMI  = 0;
   localparam int SRC_BRK  = 1;
   localparam int SRC_IRQ  = 2;
   localparam int SRC_DMAC = 10;
   localparam int SRC_ITU  = 14;
   localparam int SRC_SCI  = 19;
   localparam int SRC_PRT  = 21;
   localparam int SRC_WDT  = 22;
   localparam int SRC_REF  = 23;

   // fixed levels
   localparam logic [4:0] LEVEL_NMI = 5'd16;
   localparam logic [4:0] LEVEL_BRK = 5'd15;

   // opcodes
   localparam logic [2:0] OP_READ16   = 3'd0;
   localparam logic [2:0] OP_READ8    = 3'd1;
   localparam logic [2:0] OP_WRITE16  = 3'd2;
   localparam logic [2:0] OP_WRITE8   = 3'd3;
   localparam logic [2:0] OP_ASSERT   = 3'd4;
   localparam logic [2:0] OP_DEASSERT = 3'd5;

   // priority register offsets
   localparam logic [3:0] REG_IPRA = 4'h4;
   localparam logic [3:0] REG_IPRB = 4'h6;
   localparam logic [3:0] REG_IPRC = 4'h8;
   localparam logic [3:0] REG_IPRD = 4'hA;
   localparam logic [3:0] REG_IPRE = 4'hC;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [3:0]       reg_offset;
      logic [15:0]      write_data;
      logic [SRC_W-1:0] source;
      logic [1:0]       vector_offset;
   } pic_item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq_update;
      logic [6:0]  irq_vector;
      logic [4:0]  irq_level;
   } pic_result_type;

   typedef struct packed {
      logic load_item;
      logic apply;
      logic group;
      logic merge;
      logic load_out;
   } pic_cmd_type;

   typedef struct packed {
      logic evaluate;
   } pic_sts_type;

   // fixed base vector of each source
   function automatic logic [6:0] base_vec(input logic [SRC_W-1:0] s);
      logic [6:0] v;
      case (s)
         5'd0:    v = 7'd11;
         5'd1:    v = 7'd12;
         5'd2:    v = 7'd64;
         5'd3:    v = 7'd65;
         5'd4:    v = 7'd66;
         5'd5:    v = 7'd67;
         5'd6:    v = 7'd68;
         5'd7:    v = 7'd69;
         5'd8:    v = 7'd70;
         5'd9:    v = 7'd71;
         5'd10:   v = 7'd72;
         5'd11:   v = 7'd76;
         5'd12:   v = 7'd80;
         5'd13:   v = 7'd84;
         5'd14:   v = 7'd80;
         5'd15:   v = 7'd84;
         5'd16:   v = 7'd88;
         5'd17:   v = 7'd92;
         5'd18:   v = 7'd96;
         5'd19:   v = 7'd100;
         5'd20:   v = 7'd104;
         5'd21:   v = 7'd108;
         5'd22:   v = 7'd112;
         5'd23:   v = 7'd113;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/core/pic_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_req_if / pic_rsp_if
// valid/ready channels carrying request and response items
// ----------------------------------------------------------------------------
interface pic_req_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                opcode;
   logic [3:0]                reg_offset;
   logic [15:0]               write_data;
   logic [pic_pkg::SRC_W-1:0] source_num;
   logic [1:0]                vector_offset;

   modport source (output valid, output opcode, output reg_offset, output write_data,
                   output source_num, output vector_offset, input ready);
   modport sink (input valid, input opcode, input reg_offset, input write_data,
                 input source_num, input vector_offset, output ready);
endinterface

interface pic_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        irq_update;
   logic [6:0]  irq_vector;
   logic [4:0]  irq_level;

   modport source (output valid, output read_data, output irq_update, output irq_vector,
                   output irq_level, input ready);
   modport sink (input valid, input read_data, input irq_update, input irq_vector,
                 input irq_level, output ready);
endinterface

>>> rtl/core/pic_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_ctrl
// sequencer: accept, apply, two-step priority select if evaluating, to output
// ----------------------------------------------------------------------------
module pic_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pic_pkg::pic_sts_type sts,
   output pic_pkg::pic_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_GROUP,
      ST_MERGE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.load_item = req_valid && req_ready;
      cmd.apply     = (state_ff == ST_APPLY);
      cmd.group     = (state_ff == ST_GROUP);
      cmd.merge     = (state_ff == ST_MERGE);
      cmd.load_out  = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_APPLY;
         ST_APPLY: state_in = sts.evaluate ? ST_GROUP : ST_DONE;
         ST_GROUP: state_in = ST_MERGE;
         ST_MERGE: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> rtl/core/pic_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_datapath
// priority registers, pending and offset state, priority select, output register
// ----------------------------------------------------------------------------
module pic_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  pic_pkg::pic_cmd_type    cmd,
   input  pic_pkg::pic_item_type   item,
   output pic_pkg::pic_sts_type    sts,
   output pic_pkg::pic_result_type result
);

   localparam int N  = pic_pkg::NUM_SOURCES;
   localparam int G  = pic_pkg::NUM_GROUPS;
   localparam int GS = pic_pkg::GROUP_SIZE;

   pic_pkg::pic_item_type   item_ff;
   pic_pkg::pic_result_type work_ff, work_in;
   pic_pkg::pic_result_type out_ff;

   logic [3:0] lvl_ff [pic_pkg::SRC_IRQ:N-1];
   logic [3:0] lvl_in [pic_pkg::SRC_IRQ:N-1];
   logic [N-1:0] pend_ff, pend_in;
   logic [1:0] ofs_ff [N];
   logic [1:0] ofs_in [N];

   logic [4:0] grp_lvl_ff [G];
   logic [6:0] grp_vec_ff [G];
   logic [4:0] grp_lvl_in [G];
   logic [6:0] grp_vec_in [G];

   logic [3:0]  reg_base;
   logic [15:0] reg_rd;
   logic [15:0] wr_val;
   logic        wr_en;
   logic        src_ok;
   logic [4:0]  eff_lvl [N];

   assign reg_base = {item_ff.reg_offset[3:1], 1'b0};
   assign src_ok   = (item_ff.source < pic_pkg::SRC_W'(N));
   assign sts.evaluate = src_ok &&
      ((item_ff.opcode == pic_pkg::OP_ASSERT) || (item_ff.opcode == pic_pkg::OP_DEASSERT));
   assign result = out_ff;

   // effective level of each source, nmi and break fixed
   always_comb begin
      eff_lvl[pic_pkg::SRC_NMI] = pic_pkg::LEVEL_NMI;
      eff_lvl[pic_pkg::SRC_BRK] = pic_pkg::LEVEL_BRK;
      for (int s = pic_pkg::SRC_IRQ; s < N; s++) begin
         eff_lvl[s] = {1'b0, lvl_ff[s]};
      end
   end

   // register read view
   always_comb begin
      case (reg_base)
         pic_pkg::REG_IPRA: reg_rd = {lvl_ff[2], lvl_ff[3], lvl_ff[4], lvl_ff[5]};
         pic_pkg::REG_IPRB: reg_rd = {lvl_ff[6], lvl_ff[7], lvl_ff[8], lvl_ff[9]};
         pic_pkg::REG_IPRC: reg_rd = {lvl_ff[10], lvl_ff[12], lvl_ff[14], lvl_ff[15]};
         pic_pkg::REG_IPRD: reg_rd = {lvl_ff[16], lvl_ff[17], lvl_ff[18], lvl_ff[19]};
         pic_pkg::REG_IPRE: reg_rd = {lvl_ff[20], lvl_ff[21], lvl_ff[22], 4'h0};
         default:           reg_rd = 16'h0000;
      endcase
   end

   // write value, byte writes merge with current contents
   always_comb begin
      wr_en  = 1'b0;
      wr_val = item_ff.write_data;
      if (item_ff.opcode == pic_pkg::OP_WRITE16) begin
         wr_en = !item_ff.reg_offset[0];
      end else if (item_ff.opcode == pic_pkg::OP_WRITE8) begin
         wr_en = 1'b1;
         if (item_ff.reg_offset[0]) begin
            wr_val = {reg_rd[15:8], item_ff.write_data[7:0]};
         end else begin
            wr_val = {item_ff.write_data[7:0], reg_rd[7:0]};
         end
      end
   end

   always_comb begin
      lvl_in = lvl_ff;
      if (cmd.apply && wr_en) begin
         case (reg_base)
            pic_pkg::REG_IPRA: begin
               lvl_in[2] = wr_val[15:12]; lvl_in[3] = wr_val[11:8];
               lvl_in[4] = wr_val[7:4];   lvl_in[5] = wr_val[3:0];
            end
            pic_pkg::REG_IPRB: begin
               lvl_in[6] = wr_val[15:12]; lvl_in[7] = wr_val[11:8];
               lvl_in[8] = wr_val[7:4];   lvl_in[9] = wr_val[3:0];
            end
            pic_pkg::REG_IPRC: begin
               lvl_in[10] = wr_val[15:12]; lvl_in[11] = wr_val[15:12];
               lvl_in[12] = wr_val[11:8];  lvl_in[13] = wr_val[11:8];
               lvl_in[14] = wr_val[7:4];   lvl_in[15] = wr_val[3:0];
            end
            pic_pkg::REG_IPRD: begin
               lvl_in[16] = wr_val[15:12]; lvl_in[17] = wr_val[11:8];
               lvl_in[18] = wr_val[7:4];   lvl_in[19] = wr_val[3:0];
            end
            pic_pkg::REG_IPRE: begin
               lvl_in[20] = wr_val[15:12]; lvl_in[21] = wr_val[11:8];
               lvl_in[22] = wr_val[7:4];   lvl_in[23] = wr_val[7:4];
            end
            default: ;
         endcase
      end
   end

   // pending and offset update
   always_comb begin
      pend_in = pend_ff;
      ofs_in  = ofs_ff;
      if (cmd.apply && src_ok) begin
         if (item_ff.opcode == pic_pkg::OP_ASSERT) begin
            pend_in[item_ff.source] = 1'b1;
            ofs_in[item_ff.source]  = item_ff.vector_offset;
         end else if (item_ff.opcode == pic_pkg::OP_DEASSERT) begin
            pend_in[item_ff.source] = 1'b0;
         end
      end
   end

   // first step: winner of each group of sources
   always_comb begin
      for (int g = 0; g < G; g++) begin
         grp_lvl_in[g] = 5'd0;
         grp_vec_in[g] = 7'd0;
         for (int k = 0; k < GS; k++) begin
            if (pend_ff[g*GS+k] && (eff_lvl[g*GS+k] > grp_lvl_in[g])) begin
               grp_lvl_in[g] = eff_lvl[g*GS+k];
               grp_vec_in[g] = pic_pkg::base_vec(pic_pkg::SRC_W'(g*GS+k))
                               + {5'd0, ofs_ff[g*GS+k]};
            end
         end
      end
   end

   // apply fills read data, merge fills the request fields
   always_comb begin
      work_in = work_ff;
      if (cmd.apply) begin
         work_in            = '0;
         work_in.irq_update = sts.evaluate;
         if (item_ff.opcode == pic_pkg::OP_READ16) begin
            work_in.read_data = item_ff.reg_offset[0] ? 16'h0000 : reg_rd;
         end else if (item_ff.opcode == pic_pkg::OP_READ8) begin
            work_in.read_data = item_ff.reg_offset[0] ? {8'h00, reg_rd[7:0]}
                                                      : {8'h00, reg_rd[15:8]};
         end
      end else if (cmd.merge) begin
         work_in.irq_level  = 5'd0;
         work_in.irq_vector = 7'd0;
         for (int g = 0; g < G; g++) begin
            if (grp_lvl_ff[g] > work_in.irq_level) begin
               work_in.irq_level  = grp_lvl_ff[g];
               work_in.irq_vector = grp_vec_ff[g];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         for (int s = pic_pkg::SRC_IRQ; s < N; s++) begin
            lvl_ff[s] <= 4'h0;
         end
         for (int s = 0; s < N; s++) begin
            ofs_ff[s] <= 2'd0;
         end
      end else begin
         pend_ff <= pend_in;
         lvl_ff  <= lvl_in;
         ofs_ff  <= ofs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= item;
      end
      if (cmd.group) begin
         grp_lvl_ff <= grp_lvl_in;
         grp_vec_ff <= grp_vec_in;
      end
      work_ff <= work_in;
      if (cmd.load_out) begin
         out_ff <= work_ff;
      end
   end

endmodule

>>> rtl/core/priority_interrupt_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_interrupt_controller_top
// vectored priority interrupt controller with 24 sources
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one item: a register read or write (16-bit or byte) of
//   the five priority registers, or an assert or deassert of one source
//   rsp_chan returns exactly one item per request: read data, and for a
//   valid assert or deassert the re-evaluated vector and level
// sequence
//   register accesses: accept, apply, finish, then output register
//   assert / deassert: the same, with the priority select after apply
//   (six-way group winners, then a four-way merge, each registered)
//   one item in flight: the next is taken after the finish step
// stalls
//   the response sits in an output register; the next item is accepted
//   while it waits, and its own result holds in the finish step until
//   the output register is taken
// reset
//   synchronous, active high: levels, pending bits and offsets cleared,
//   nmi and user break keep their fixed levels 16 and 15
// ----------------------------------------------------------------------------
module priority_interrupt_controller_top (
   input  logic      clock,
   input  logic      reset,
   pic_req_if.sink   req_chan,
   pic_rsp_if.source rsp_chan
);

   pic_pkg::pic_cmd_type    cmd;
   pic_pkg::pic_sts_type    sts;
   pic_pkg::pic_item_type   item;
   pic_pkg::pic_result_type result;

   // gather request payload into one item
   always_comb begin
      item.opcode        = req_chan.opcode;
      item.reg_offset    = req_chan.reg_offset;
      item.write_data    = req_chan.write_data;
      item.source        = req_chan.source_num;
      item.vector_offset = req_chan.vector_offset;
   end

   // sequencer
   pic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // state, priority select and output register
   pic_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .item   (item),
      .sts    (sts),
      .result (result)
   );

   assign rsp_chan.read_data  = result.read_data;
   assign rsp_chan.irq_update = result.irq_update;
   assign rsp_chan.irq_vector = result.irq_vector;
   assign rsp_chan.irq_level  = result.irq_level;

endmodule
